// ----- sv/sfu_pkg.sv -----
package sfu_pkg;

   // Frame phases, one-hot
   typedef enum logic [8:0] {
      PH_MARK0 = 9'b0_0000_0001,
      PH_MARK1 = 9'b0_0000_0010,
      PH_MARK2 = 9'b0_0000_0100,
      PH_COUNT = 9'b0_0000_1000,
      PH_DATA  = 9'b0_0001_0000,
      PH_CHECK = 9'b0_0010_0000,
      PH_SUM   = 9'b0_0100_0000,
      PH_TRAIL = 9'b0_1000_0000,
      PH_HALT  = 9'b1_0000_0000
   } phase_type;

   // Event codes
   localparam logic [2:0] EV_WRITE     = 3'd0;
   localparam logic [2:0] EV_MARK_BAD  = 3'd1;
   localparam logic [2:0] EV_DONE      = 3'd2;
   localparam logic [2:0] EV_INDEX_BAD = 3'd3;
   localparam logic [2:0] EV_SUM_BAD   = 3'd4;

   // Frame bytes
   localparam logic [7:0] MARK0_BYTE   = 8'hF0;
   localparam logic [7:0] MARK1_BYTE   = 8'h7D;
   localparam logic [7:0] MARK2_BYTE   = 8'd100;
   localparam logic [7:0] TRAILER_BYTE = 8'hF7;

   // Last byte position of a 5-byte group
   localparam logic [2:0] GROUP_LAST = 3'd4;

   // Register indexes and reset values
   localparam logic CSR_BASE_ADDRESS   = 1'b0;
   localparam logic CSR_CHECK_INTERVAL = 1'b1;
   localparam logic [31:0] BASE_ADDRESS_RST   = 32'h0802_0000;
   localparam logic [15:0] CHECK_INTERVAL_RST = 16'd1000;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] address;
      logic [31:0] data;
      logic [31:0] word_position;
      logic [7:0]  got_byte;
      logic [7:0]  want_byte;
      logic        trailer_bad;
   } sfu_event_type;

endpackage

// ----- sv/sfu_core.sv -----
module sfu_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   input  logic [31:0]           base_address,
   input  logic [15:0]           check_interval,
   output logic                  evt_valid,
   output sfu_pkg::sfu_event_type evt
);
   import sfu_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] pending_ff, pending_in;
   logic [15:0] left_ff, left_in;

   logic [31:0] shift_next;
   logic [31:0] index_inc;
   logic        do_write;
   logic [31:0] write_word;

   assign shift_next = (pos_ff == 3'd0) ? {24'd0, rx_byte}
                                        : ({shift_ff[24:0], 7'd0} | {24'd0, rx_byte});
   assign index_inc  = index_ff + 32'd1;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      shift_in   = shift_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      pending_in = pending_ff;
      left_in    = left_ff;
      do_write   = 1'b0;
      write_word = pending_ff;
      evt_valid  = 1'b0;
      evt        = '0;

      if (step) begin
         unique case (phase_ff) inside
            PH_MARK0, PH_MARK1, PH_MARK2: begin
               if (phase_ff == PH_MARK0) begin
                  phase_in      = PH_MARK1;
                  evt.want_byte = MARK0_BYTE;
               end else if (phase_ff == PH_MARK1) begin
                  phase_in      = PH_MARK2;
                  evt.want_byte = MARK1_BYTE;
               end else begin
                  phase_in      = PH_COUNT;
                  evt.want_byte = MARK2_BYTE;
               end
               // wrong marker is reported but taken as that marker
               if (rx_byte != evt.want_byte) begin
                  evt_valid     = 1'b1;
                  evt.event_res = EV_MARK_BAD;
                  evt.got_byte  = rx_byte;
               end else begin
                  evt.want_byte = 8'd0;
               end
            end
            PH_TRAIL: begin
               evt_valid       = 1'b1;
               evt.event_res   = (sum_ff == shift_ff) ? EV_DONE : EV_SUM_BAD;
               evt.trailer_bad = (rx_byte != TRAILER_BYTE);
               phase_in        = PH_HALT;
            end
            PH_COUNT, PH_DATA, PH_CHECK, PH_SUM: begin
               shift_in = shift_next;
               if (pos_ff != GROUP_LAST) begin
                  pos_in = pos_ff + 3'd1;
               end else begin
                  pos_in = 3'd0;
                  if (phase_ff == PH_COUNT) begin
                     count_in = shift_next;
                     index_in = 32'd0;
                     sum_in   = 32'd0;
                     left_in  = check_interval;
                     phase_in = (shift_next == 32'd0) ? PH_SUM : PH_DATA;
                  end else if (phase_ff == PH_DATA) begin
                     pending_in = shift_next;
                     if (index_ff != 32'd0 && left_ff == 16'd0) begin
                        phase_in = PH_CHECK;
                     end else begin
                        do_write   = 1'b1;
                        write_word = shift_next;
                     end
                  end else if (phase_ff == PH_CHECK) begin
                     if (shift_next != index_ff) begin
                        evt_valid         = 1'b1;
                        evt.event_res     = EV_INDEX_BAD;
                        evt.word_position = index_ff;
                        phase_in          = PH_HALT;
                     end else begin
                        phase_in = PH_DATA;
                        do_write = 1'b1;
                     end
                  end else begin
                     // checksum group stays in the shift register
                     phase_in = PH_TRAIL;
                  end
               end
            end
            default: begin
               // halted: bytes are dropped
            end
         endcase

         if (do_write) begin
            evt_valid         = 1'b1;
            evt.event_res     = EV_WRITE;
            evt.address       = base_address + {index_ff[29:0], 2'b00};
            evt.data          = write_word;
            evt.word_position = index_ff;
            sum_in            = sum_ff + write_word;
            left_in           = (left_ff == 16'd0) ? (check_interval - 16'd1)
                                                   : (left_ff - 16'd1);
            index_in          = index_inc;
            if (index_inc == count_ff) begin
               phase_in = PH_SUM;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MARK0;
         pos_ff     <= 3'd0;
         shift_ff   <= 32'd0;
         index_ff   <= 32'd0;
         count_ff   <= 32'd0;
         sum_ff     <= 32'd0;
         pending_ff <= 32'd0;
         left_ff    <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         shift_ff   <= shift_in;
         index_ff   <= index_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         pending_ff <= pending_in;
         left_ff    <= left_in;
      end
   end

endmodule

// ----- sv/sfu_out_reg.sv -----
module sfu_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sfu_pkg::sfu_event_type evt,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfu_pkg::sfu_event_type rsp
);
   import sfu_pkg::*;

   logic          valid_ff, valid_in;
   sfu_event_type evt_ff;

   // free when empty or being drained this cycle
   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = evt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         evt_ff <= evt;
      end
   end

endmodule

// ----- sv/sysex_firmware_upload_receiver.sv -----
// Firmware upload frame receiver.
// Request channel (req_valid/req_ready/req_rx_byte): one received serial byte
// per request. The frame is F0, 7D, 64 hex, then 5-byte groups packed 7 bits
// per byte (word count, data words with index check words, checksum), then F7.
// Response channel (rsp_*): at most one event per byte - a word write with its
// flash address, a header marker mismatch, upload done, index check failed or
// checksum failed. Bytes that cause no event produce no response.
// CSR channel (csr_valid/csr_ready/csr_index/csr_wdata): index 0 is the base
// address, index 1 the check interval (low 16 bits). Always ready; write only
// while no upload byte is in flight.
// A taken request waits in the input register, is decoded once the response
// register is free and its event registered there. Throughput is one byte per
// cycle unless rsp_ready stalls, set by the single decode step between them.
// Reset: frame decoder back to waiting for the first marker, registers to
// their defaults, both pipeline registers empty.
// Stall: while a response waits on rsp_ready the held byte is not decoded;
// req_ready drops once the input register is also occupied.
module sysex_firmware_upload_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_address,
   output logic [31:0] rsp_data,
   output logic [31:0] rsp_word_position,
   output logic [7:0]  rsp_got_byte,
   output logic [7:0]  rsp_want_byte,
   output logic        rsp_trailer_bad,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import sfu_pkg::*;

   // configuration registers
   logic [31:0] base_address_ff;
   logic [15:0] check_interval_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;

   logic          out_free;
   logic          advance;
   logic          evt_valid;
   sfu_event_type evt;
   sfu_event_type rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff   <= BASE_ADDRESS_RST;
         check_interval_ff <= CHECK_INTERVAL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_wdata;
            CSR_CHECK_INTERVAL: check_interval_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // byte is decoded once the response register can take its event
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfu_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .base_address   (base_address_ff),
      .check_interval (check_interval_ff),
      .evt_valid      (evt_valid),
      .evt            (evt)
   );

   sfu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (evt_valid),
      .evt       (evt),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_event_res     = rsp.event_res;
   assign rsp_address       = rsp.address;
   assign rsp_data          = rsp.data;
   assign rsp_word_position = rsp.word_position;
   assign rsp_got_byte      = rsp.got_byte;
   assign rsp_want_byte     = rsp.want_byte;
   assign rsp_trailer_bad   = rsp.trailer_bad;

endmodule

// ----- bench/sysex_firmware_upload_receiver_checker.sv -----
`timescale 1ns / 100ps
module sysex_firmware_upload_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_event_res,
   input  logic [31:0] rsp_address,
   input  logic [31:0] rsp_data,
   input  logic [31:0] rsp_word_position,
   input  logic [7:0]  rsp_got_byte,
   input  logic [7:0]  rsp_want_byte,
   input  logic        rsp_trailer_bad,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          errors,
   output int          outstanding
);
   import sfu_pkg::*;

   // register copies
   logic [31:0] base_q;
   logic [15:0] interval_q;

   // frame decoder copy
   phase_type   phase_q;
   logic [2:0]  gpos_q;
   logic [31:0] shift_q;
   logic [31:0] index_q;
   logic [31:0] count_q;
   logic [31:0] sum_q;
   logic [31:0] held_q;
   logic [15:0] left_q;

   sfu_event_type due_events[$];
   int mismatches = 0;
   int due_count  = 0;

   assign errors      = mismatches;
   assign outstanding = due_count;

   function automatic void write_event(output sfu_event_type ev);
      ev               = '0;
      ev.event_res     = EV_WRITE;
      ev.address       = base_q + (index_q << 2);
      ev.data          = held_q;
      ev.word_position = index_q;
      sum_q            = sum_q + held_q;
      if (left_q == 16'd0) begin
         left_q = interval_q - 16'd1;
      end else begin
         left_q = left_q - 16'd1;
      end
      index_q = index_q + 32'd1;
      if (index_q == count_q) begin
         phase_q = PH_SUM;
      end
   endfunction

   function automatic bit marker_check(input logic [7:0] b, input logic [7:0] want,
                                       input phase_type next, output sfu_event_type ev);
      ev      = '0;
      phase_q = next;
      if (b == want) begin
         return 1'b0;
      end
      ev.event_res = EV_MARK_BAD;
      ev.got_byte  = b;
      ev.want_byte = want;
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output sfu_event_type ev);
      logic [31:0] w;
      ev = '0;
      case (phase_q) inside
         PH_MARK0: return marker_check(b, MARK0_BYTE, PH_MARK1, ev);
         PH_MARK1: return marker_check(b, MARK1_BYTE, PH_MARK2, ev);
         PH_MARK2: return marker_check(b, MARK2_BYTE, PH_COUNT, ev);
         PH_TRAIL: begin
            ev.event_res   = (sum_q == shift_q) ? EV_DONE : EV_SUM_BAD;
            ev.trailer_bad = (b != TRAILER_BYTE);
            phase_q        = PH_HALT;
            return 1'b1;
         end
         PH_COUNT, PH_DATA, PH_CHECK, PH_SUM: ;
         default: return 1'b0;
      endcase

      // 7 bits per byte, but every bit of the byte is OR'd in
      if (gpos_q == 3'd0) begin
         shift_q = {24'd0, b};
      end else begin
         shift_q = (shift_q << 7) | {24'd0, b};
      end
      if (gpos_q < GROUP_LAST) begin
         gpos_q = gpos_q + 3'd1;
         return 1'b0;
      end
      gpos_q = 3'd0;
      w      = shift_q;

      case (phase_q)
         PH_COUNT: begin
            count_q = w;
            index_q = 32'd0;
            sum_q   = 32'd0;
            left_q  = interval_q;
            phase_q = (w == 32'd0) ? PH_SUM : PH_DATA;
            return 1'b0;
         end
         PH_DATA: begin
            held_q = w;
            if (index_q != 32'd0 && left_q == 16'd0) begin
               phase_q = PH_CHECK;
               return 1'b0;
            end
            write_event(ev);
            return 1'b1;
         end
         PH_CHECK: begin
            if (w != index_q) begin
               ev.event_res     = EV_INDEX_BAD;
               ev.word_position = index_q;
               phase_q          = PH_HALT;
               return 1'b1;
            end
            phase_q = PH_DATA;
            write_event(ev);
            return 1'b1;
         end
         default: begin
            // checksum group stays in shift_q for the trailer
            phase_q = PH_TRAIL;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      sfu_event_type ev;
      if (reset) begin
         base_q     = BASE_ADDRESS_RST;
         interval_q = CHECK_INTERVAL_RST;
         phase_q    = PH_MARK0;
         gpos_q     = 3'd0;
         shift_q    = 32'd0;
         index_q    = 32'd0;
         count_q    = 32'd0;
         sum_q      = 32'd0;
         held_q     = 32'd0;
         left_q     = 16'd0;
         due_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_events.size() == 0) begin
               $error("response with no request pending: event_res %0d", rsp_event_res);
               mismatches++;
            end else begin
               ev = due_events.pop_front();
               check_field("event_res", 32'(ev.event_res), 32'(rsp_event_res));
               check_field("address", ev.address, rsp_address);
               check_field("data", ev.data, rsp_data);
               check_field("word_position", ev.word_position, rsp_word_position);
               check_field("got_byte", 32'(ev.got_byte), 32'(rsp_got_byte));
               check_field("want_byte", 32'(ev.want_byte), 32'(rsp_want_byte));
               check_field("trailer_bad", 32'(ev.trailer_bad), 32'(rsp_trailer_bad));
            end
         end
         if (req_valid && req_ready) begin
            if (decode_byte(req_rx_byte, ev)) begin
               due_events.push_back(ev);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_ADDRESS:   base_q     = csr_wdata;
               CSR_CHECK_INTERVAL: interval_q = csr_wdata[15:0];
            endcase
         end
      end
      due_count = due_events.size();
   end

endmodule

// ----- bench/sysex_firmware_upload_receiver_tb.sv -----
`timescale 1ns / 100ps
module sysex_firmware_upload_receiver_tb;
   import sfu_pkg::*;

   // How the single upload frame of this run finishes. The block halts for
   // good after done or an error and reset is only applied once, so each run
   // picks one ending; the seed spreads them over runs. Short frames are
   // topped up with bytes the halted block must ignore.
   typedef enum logic [2:0] {
      END_CLEAN,
      END_BAD_TRAILER,
      END_BAD_SUM,
      END_BAD_INDEX,
      END_EMPTY
   } frame_end_type;

   localparam int ITEM_TARGET = 700;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_address;
   logic [31:0] rsp_data;
   logic [31:0] rsp_word_position;
   logic [7:0]  rsp_got_byte;
   logic [7:0]  rsp_want_byte;
   logic        rsp_trailer_bad;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic        csr_index   = 1'b0;
   logic [31:0] csr_wdata   = 32'd0;

   int mismatch_count;
   int pending_count;

   // Set for the tail of the run: no more idling on either side.
   bit calm = 1'b0;
   // Requests still to go before the sender's next gap.
   int gap_credit = 0;
   int sent_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sysex_firmware_upload_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_address       (rsp_address),
      .rsp_data          (rsp_data),
      .rsp_word_position (rsp_word_position),
      .rsp_got_byte      (rsp_got_byte),
      .rsp_want_byte     (rsp_want_byte),
      .rsp_trailer_bad   (rsp_trailer_bad),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   sysex_firmware_upload_receiver_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_address       (rsp_address),
      .rsp_data          (rsp_data),
      .rsp_word_position (rsp_word_position),
      .rsp_got_byte      (rsp_got_byte),
      .rsp_want_byte     (rsp_want_byte),
      .rsp_trailer_bad   (rsp_trailer_bad),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .errors            (mismatch_count),
      .outstanding       (pending_count)
   );

   // Word packed so that the OR'd 7-bit folding gives it back exactly:
   // top 4 bits in the first byte, then four clean 7-bit chunks.
   function automatic logic [39:0] pack_clean(input logic [31:0] w);
      return {4'd0, w[31:28], 1'b0, w[27:21], 1'b0, w[20:14], 1'b0, w[13:7], 1'b0, w[6:0]};
   endfunction

   // One request; valid goes up without looking at ready and holds until taken.
   // Outside the calm tail an idle gap comes now and then, with free-running
   // stretches of up to 31 requests in between.
   task automatic send_byte(input logic [7:0] b);
      if (!calm && gap_credit == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
         gap_credit = $urandom_range(0, 30);
      end else if (gap_credit > 0) begin
         gap_credit--;
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Five bytes of a group, first byte in the top lane.
   task automatic send_group(input logic [39:0] g);
      int k;
      for (k = 4; k >= 0; k--) begin
         send_byte(g[k*8 +: 8]);
      end
   endtask

   // Leaves valid high; the caller drops it after the last write.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Registers are only touched with the block idle: stop offering, let every
   // expected response drain, then wait out a byte that gives none.
   // Upper half of the interval write is junk the block must drop.
   task automatic reconfigure(input logic [31:0] base, input logic [15:0] interval);
      logic [31:0] junk;
      junk = $urandom;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write(CSR_BASE_ADDRESS, base);
      csr_write(CSR_CHECK_INTERVAL, {junk[31:16], interval});
      csr_valid <= 1'b0;
   endtask

   // Receiver: ready stays low until the first response shows, then a long
   // hold-off while the sender keeps going, so both the response and input
   // registers fill and req_ready drops. After that, rsp_ready alternates between
   // free runs and stalls.
   initial begin : receiver
      bit held_off;
      held_off = 1'b0;
      forever begin
         if (!held_off) begin
            @(posedge clock);
            if (rsp_valid) begin
               held_off = 1'b1;
               repeat (150) @(posedge clock);
            end
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      frame_end_type ending;
      logic [7:0]  markers [3];
      logic [39:0] g;
      logic [31:0] w, sum, words, trip, r1, r2;
      logic [15:0] interval, left;
      logic [7:0]  trailer;
      int          bad_marker, i, k, n;
      bit          halted;

      markers[0] = MARK0_BYTE;
      markers[1] = MARK1_BYTE;
      markers[2] = MARK2_BYTE;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Interval of one: a check group after every word from index 1 on.
      // Base just below the top, so the third word's address wraps to zero.
      interval = 16'd1;
      reconfigure(32'hFFFF_FFF8, interval);

      if ($urandom_range(0, 15) == 0) begin
         ending = END_EMPTY;
      end else begin
         ending = frame_end_type'($urandom_range(0, 3));
      end

      // Header; at most one marker is wrong, which is reported and then
      // consumed as that marker.
      bad_marker = $urandom_range(0, 3);
      for (i = 0; i < 3; i++) begin
         send_byte((i == bad_marker) ? 8'($urandom_range(0, 255)) : markers[i]);
      end

      words = (ending == END_EMPTY) ? 32'd0 : $urandom_range(110, 130);
      trip  = $urandom_range(5, 55);
      send_group(pack_clean(words));

      // Mirror of when the block wants a check group, needed to build a frame
      // that gets past the checks.
      sum    = 32'd0;
      left   = interval;
      halted = 1'b0;
      for (i = 0; i < words && !halted; i++) begin
         if (i == 4) begin
            // bulk of the frame: short random interval, base at zero
            interval = 16'($urandom_range(3, 15));
            reconfigure(32'd0, interval);
         end else if (i == words / 2) begin
            interval = 16'($urandom_range(3, 15));
            reconfigure($urandom, interval);
         end else if (i == (words * 3) / 4) begin
            // widest interval, only picked up at the next reload
            interval = 16'hFFFF;
            reconfigure(32'hFFFF_FFFF, interval);
         end
         if (i >= words - 15) begin
            calm = 1'b1;
         end

         // first words: all clear, all set, high bits only, low bits only
         r1 = $urandom;
         r2 = $urandom;
         case (i)
            0:       g = {5{8'h00}};
            1:       g = {5{8'hFF}};
            2:       g = {5{8'h80}};
            3:       g = {5{8'h7F}};
            default: g = ($urandom_range(0, 3) == 0) ? pack_clean(r1) : {r1, r2[7:0]};
         endcase
         w = {24'd0, g[39:32]};
         for (k = 3; k >= 0; k--) begin
            w = (w << 7) | {24'd0, g[k*8 +: 8]};
         end
         send_group(g);
         sum = sum + w;

         if (i > 0 && left == 16'd0) begin
            if (ending == END_BAD_INDEX && i >= trip) begin
               // check group off by one bit: the word is dropped, block halts
               send_group(pack_clean(i ^ (32'd1 << $urandom_range(0, 31))));
               halted = 1'b1;
            end else begin
               send_group(pack_clean(i));
            end
         end
         left = (left == 16'd0) ? interval - 16'd1 : left - 16'd1;
      end

      calm = 1'b1;
      if (!halted) begin
         if (ending == END_BAD_SUM) begin
            sum = sum ^ (32'd1 << $urandom_range(0, 31));
         end
         send_group(pack_clean(sum));
         trailer = 8'($urandom_range(0, 255));
         if (trailer == TRAILER_BYTE) begin
            trailer = 8'h00;
         end
         if (ending == END_CLEAN ||
             (ending != END_BAD_TRAILER && $urandom_range(0, 1) == 0)) begin
            trailer = TRAILER_BYTE;
         end
         send_byte(trailer);
      end

      // block has halted: these must all be swallowed without a response
      for (n = 0; n < 20 || sent_count < ITEM_TARGET; n++) begin
         send_byte(8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      for (n = 0; n < 5000 && pending_count != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_count != 0) begin
         $error("%0d expected responses never arrived", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
